// ===== sv/esc_pkg.sv =====
package esc_pkg;

    // field widths
    localparam int unsigned RAW_T_W   = 20;
    localparam int unsigned RAW_P_W   = 20;
    localparam int unsigned RAW_H_W   = 16;
    localparam int unsigned TEMP_W    = 24;
    localparam int unsigned PRESS_W   = 24;
    localparam int unsigned HUM_W     = 17;

    // configuration port
    localparam int unsigned CFG_AW    = 6;
    localparam int unsigned CFG_DW    = 64;
    localparam int unsigned CFG_LSB   = 3;

    typedef enum logic [2:0] {
        REG_TEMP_TRIM  = 3'd0,
        REG_PRESS_LOW  = 3'd1,
        REG_PRESS_HIGH = 3'd2,
        REG_PRESS_NINE = 3'd3,
        REG_HUM_TRIM   = 3'd4
    } t_reg_idx;

    // compensation constants
    localparam int unsigned TEMP_P_OFS   = 128000;
    localparam logic [47:0] PRESS_OFS    = 48'h8000_0000_0000;
    localparam int unsigned PRESS_BASE   = 1048576;
    localparam int unsigned PRESS_SCALE  = 3125;
    localparam int unsigned HUM_T_OFS    = 76800;
    localparam int unsigned HUM_HC_OFS   = 2097152;
    localparam int unsigned HUM_MAX      = 419430400;
    localparam int unsigned HUM_RND      = 16384;
    localparam int unsigned HUM_HB_OFS   = 32768;
    localparam int unsigned HUM_HD_RND   = 8192;

    // pipeline stage numbers
    localparam int unsigned DIV_STEPS    = 64;
    localparam int unsigned STG_TEMP     = 5;
    localparam int unsigned STG_HUM      = 17;
    localparam int unsigned STG_DIV_IN   = 12;
    localparam int unsigned STG_DIV_OUT  = STG_DIV_IN + DIV_STEPS;
    localparam int unsigned STG_LAST     = STG_DIV_OUT + 7;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [PRESS_W-1:0]       press_pascal;
        logic [HUM_W-1:0]         hum_q10;
        logic                     press_invalid;
    } t_result;

endpackage

// ===== sv/esc_in_if.sv =====
interface esc_in_if;
    import esc_pkg::*;

    logic               valid;
    logic               ready;
    logic [RAW_T_W-1:0] raw_temp;
    logic [RAW_P_W-1:0] raw_press;
    logic [RAW_H_W-1:0] raw_hum;

    modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
    modport sink   (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

// ===== sv/esc_out_if.sv =====
interface esc_out_if;
    import esc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_centi;
    logic [PRESS_W-1:0]       press_pascal;
    logic [HUM_W-1:0]         hum_q10;
    logic                     press_invalid;

    modport source (output valid, temp_centi, press_pascal, hum_q10, press_invalid,
                    input ready);
    modport sink   (input valid, temp_centi, press_pascal, hum_q10, press_invalid,
                    output ready);
endinterface

// ===== sv/env_sensor_compensation_core.sv =====
// channel    dir  handshake      beat
// i_sample   in   valid/ready    raw_temp, raw_press, raw_hum
// o_result   out  valid/ready    temp_centi, press_pascal, hum_q10, press_invalid
// apb        in   psel/penable   trim register writes and reads, 64-bit data
//
// one beat per cycle while no stall holds the pipeline; 83 pipeline stages plus
// the output buffer, their number set mostly by the 64-step radix-2 pressure divider
// i_rst_n (synchronous) clears the valid bits, the output buffer and the trims
// a full output buffer that is not drained, with a valid beat in the last stage,
// freezes every stage together; one beat can still enter while a result waits in the buffer
module env_sensor_compensation_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    esc_in_if.sink                      i_sample,
    esc_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esc_pkg::CFG_AW-1:0]  paddr,
    input  logic [esc_pkg::CFG_DW-1:0]  pwdata,
    output logic [esc_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import esc_pkg::*;

    // trim registers
    logic [47:0] r_temp_trim;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_nine;
    logic [63:0] r_hum_trim;
    t_reg_idx    w_cfg_idx;
    logic        w_cfg_wr;

    // coefficient views
    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0]         h1, h3;
    logic signed [15:0] h2;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    // flow control
    logic                en;
    logic [STG_LAST:1]   r_vld;
    t_result             r_ob [0:1];
    logic                r_ob_wp, r_ob_rp;
    logic [1:0]          r_ob_cnt;
    logic                w_push, w_pop;
    t_result             w_res;

    // delay lines
    logic [20:0]              r_pp_dl  [1:9];
    logic [RAW_H_W-1:0]       r_rh_dl  [1:5];
    logic signed [TEMP_W-1:0] r_temp_dl[STG_TEMP:STG_LAST];
    logic [HUM_W-1:0]         r_hum_dl [STG_HUM:STG_LAST];
    logic                     r_inv_dl [STG_DIV_IN:STG_LAST];
    logic signed [16:0]       r_hv_dl  [8:14];

    // temperature stages
    logic signed [18:0] n1_a0, r1_a0;
    logic signed [17:0] n1_b0, r1_b0;
    logic signed [34:0] w2_ma;
    logic signed [35:0] w2_mb;
    logic [31:0]        r2_ma, r2_mb;
    logic signed [31:0] w3_a, w3_mbs_full;
    logic signed [19:0] w3_mbs;
    logic signed [35:0] w3_mbt;
    logic signed [20:0] r3_a;
    logic [31:0]        r3_mbt;
    logic signed [31:0] w4_b_full;
    logic signed [21:0] n4_tf, r4_tf;
    logic signed [25:0] w5_t;
    logic signed [22:0] n5_v1, r5_v1, n5_hv, r5_hv;

    // pressure stages before the divider
    logic signed [45:0] n6_sq, r6_sq;
    logic signed [38:0] n6_m5, r6_m5, n6_m2, r6_m2, r7_m2;
    logic signed [61:0] n7_x6, r7_x6, n7_x3, r7_x3;
    logic signed [56:0] n7_v2p, r7_v2p;
    logic signed [62:0] n8_v2, r8_v2;
    logic signed [54:0] n8_v1b, r8_v1b;
    logic signed [55:0] n9_s, r9_s;
    logic signed [63:0] w9_v2x, n9_d, r9_d;
    logic signed [63:0] w10_s64;
    logic [43:0]        r10_nlo;
    logic [31:0]        r10_nhi;
    logic [47:0]        r10_slo;
    logic [31:0]        r10_shi;
    logic [63:0]        n11_num, r11_num, w11_prod;
    logic signed [30:0] n11_den, r11_den;
    logic               w12_inv;

    // divider
    logic [30:0] r_dv_rem [0:DIV_STEPS];
    logic [63:0] r_dv_dq  [0:DIV_STEPS];
    logic [30:0] r_dv_md  [0:DIV_STEPS];
    logic        r_dv_neg [0:DIV_STEPS];
    logic [31:0] w_dv_try [1:DIV_STEPS];
    logic        w_dv_ge  [1:DIV_STEPS];
    logic [30:0] n_dv_rem [1:DIV_STEPS];

    // pressure stages after the divider
    logic [63:0]        r77_p, r78_p, r79_p, r80_p, r81_p;
    logic signed [63:0] w78_ps;
    logic [63:0]        r78_ll;
    logic [31:0]        r78_lh, r78_w2hi;
    logic signed [48:0] r78_w2lo;
    logic [63:0]        r79_sq, r79_w2raw;
    logic signed [48:0] r80_x9lo;
    logic [31:0]        r80_x9hi;
    logic signed [63:0] r80_w2, r81_w2;
    logic [63:0]        w81_x;
    logic signed [63:0] r81_w1;
    logic [39:0]        r82_s;
    logic signed [19:0] w83_p7s;
    logic [31:0]        w83_res;
    logic [PRESS_W-1:0] r83_press;

    // humidity stages
    logic signed [34:0] w6_hm;
    logic [31:0]        r6_hm, n6_hbase, r6_hbase;
    logic [31:0]        w7_hx;
    logic signed [16:0] r7_v;
    logic signed [24:0] r8_ha0;
    logic signed [25:0] r8_hb0;
    logic signed [14:0] r9_ha;
    logic signed [16:0] r9_hb;
    logic signed [31:0] r10_hc0;
    logic [31:0]        r11_hc;
    logic signed [47:0] w12_hd;
    logic [31:0]        r12_hd0;
    logic signed [17:0] r13_hd;
    logic signed [34:0] w14_vv;
    logic [31:0]        r14_vv, r15_vv, r16_vv;
    logic signed [16:0] w15_hs;
    logic signed [33:0] w15_sq;
    logic [31:0]        r15_sq;
    logic signed [24:0] w16_sh;
    logic signed [33:0] w16_t;
    logic [31:0]        r16_t;
    logic [31:0]        w17_vf;
    logic [HUM_W-1:0]   n17_hum;

    // coefficient fields
    assign t1 = r_temp_trim[15:0];
    assign t2 = $signed(r_temp_trim[31:16]);
    assign t3 = $signed(r_temp_trim[47:32]);
    assign p1 = r_press_low[15:0];
    assign p2 = $signed(r_press_low[31:16]);
    assign p3 = $signed(r_press_low[47:32]);
    assign p4 = $signed(r_press_low[63:48]);
    assign p5 = $signed(r_press_high[15:0]);
    assign p6 = $signed(r_press_high[31:16]);
    assign p7 = $signed(r_press_high[47:32]);
    assign p8 = $signed(r_press_high[63:48]);
    assign p9 = $signed(r_press_nine);
    assign h1 = r_hum_trim[7:0];
    assign h2 = $signed(r_hum_trim[23:8]);
    assign h3 = r_hum_trim[31:24];
    assign h4 = $signed(r_hum_trim[43:32]);
    assign h5 = $signed(r_hum_trim[55:44]);
    assign h6 = $signed(r_hum_trim[63:56]);

    // apb register file
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[CFG_AW-1:CFG_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim  <= '0;
            r_press_low  <= '0;
            r_press_high <= '0;
            r_press_nine <= '0;
            r_hum_trim   <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_TEMP_TRIM:  r_temp_trim  <= pwdata[47:0];
                REG_PRESS_LOW:  r_press_low  <= pwdata;
                REG_PRESS_HIGH: r_press_high <= pwdata;
                REG_PRESS_NINE: r_press_nine <= pwdata[15:0];
                REG_HUM_TRIM:   r_hum_trim   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_TEMP_TRIM:  prdata = {16'b0, r_temp_trim};
            REG_PRESS_LOW:  prdata = r_press_low;
            REG_PRESS_HIGH: prdata = r_press_high;
            REG_PRESS_NINE: prdata = {48'b0, r_press_nine};
            REG_HUM_TRIM:   prdata = r_hum_trim;
            default:        prdata = '0;
        endcase
    end

    // global advance: stall only when a valid beat is in the last stage and the buffer is full and not drained
    assign en     = !r_vld[STG_LAST] || (r_ob_cnt != 2'd2) || o_result.ready;
    assign i_sample.ready = en;
    assign w_push = r_vld[STG_LAST] && en;
    assign w_pop  = o_result.valid && o_result.ready;

    // temperature
    assign n1_a0 = $signed({2'b00, i_sample.raw_temp[19:3]}) - $signed({2'b00, t1, 1'b0});
    assign n1_b0 = $signed({2'b00, i_sample.raw_temp[19:4]}) - $signed({2'b00, t1});
    assign w2_ma = r1_a0 * t2;
    assign w2_mb = r1_b0 * r1_b0;
    assign w3_a        = $signed(r2_ma) >>> 11;
    assign w3_mbs_full = $signed(r2_mb) >>> 12;
    assign w3_mbs      = w3_mbs_full[19:0];
    assign w3_mbt      = w3_mbs * t3;
    assign w4_b_full   = $signed(r3_mbt) >>> 14;
    assign n4_tf = 22'(r3_a) + 22'($signed(w4_b_full[17:0]));
    assign w5_t  = 26'(r4_tf) * 26'sd5 + 26'sd128;
    assign n5_v1 = 23'(r4_tf) - 23'(TEMP_P_OFS);
    assign n5_hv = 23'(r4_tf) - 23'(HUM_T_OFS);

    // pressure up to the divisor
    assign n6_sq  = r5_v1 * r5_v1;
    assign n6_m5  = r5_v1 * p5;
    assign n6_m2  = r5_v1 * p2;
    assign n7_x6  = r6_sq * p6;
    assign n7_x3  = r6_sq * p3;
    assign n7_v2p = (57'(r6_m5) <<< 17) + (57'(p4) <<< 35);
    assign n8_v2  = 63'(r7_x6) + 63'(r7_v2p);
    assign n8_v1b = 55'(r7_x3 >>> 8) + (55'(r7_m2) <<< 12);
    assign n9_s   = 56'(r8_v1b) + 56'(PRESS_OFS);
    assign w9_v2x = r8_v2;
    assign n9_d   = 64'({r_pp_dl[8], 31'b0}) - w9_v2x;
    assign w10_s64 = r9_s;
    assign n11_num  = 64'(r10_nlo) + {r10_nhi, 32'b0};
    assign w11_prod = 64'(r10_slo) + {r10_shi, 32'b0};
    assign n11_den  = $signed(w11_prod[63:33]);
    assign w12_inv  = (r11_den == '0);

    // one quotient bit per divider stage
    always_comb begin
        for (int k = 1; k <= DIV_STEPS; k++) begin
            w_dv_try[k] = {r_dv_rem[k-1], r_dv_dq[k-1][63]};
            w_dv_ge[k]  = (w_dv_try[k] >= {1'b0, r_dv_md[k-1]});
            n_dv_rem[k] = w_dv_ge[k] ? 31'(w_dv_try[k] - {1'b0, r_dv_md[k-1]})
                                     : w_dv_try[k][30:0];
        end
    end

    // pressure after the quotient
    assign w78_ps  = $signed(r77_p) >>> 13;
    assign w81_x   = 64'(r80_x9lo) + {r80_x9hi, 32'b0};
    assign w83_p7s = {p7, 4'b0000};
    assign w83_res = r82_s[39:8] + 32'(w83_p7s);

    // humidity
    assign w6_hm    = h5 * r5_hv;
    assign n6_hbase = 32'({r_rh_dl[5], 14'b0}) - {h4, 20'b0} + 32'(HUM_RND);
    assign w7_hx    = r6_hbase - r6_hm;
    assign w12_hd   = $signed(r11_hc) * h2;
    assign w14_vv   = r_hv_dl[13] * r13_hd;
    assign w15_hs   = 17'($signed(r14_vv) >>> 15);
    assign w15_sq   = w15_hs * w15_hs;
    assign w16_sh   = 25'($signed(r15_sq) >>> 7);
    assign w16_t    = w16_sh * $signed({1'b0, h1});
    assign w17_vf   = r16_vv - 32'($signed(r16_t) >>> 4);

    always_comb begin
        if (w17_vf[31]) begin
            n17_hum = '0;
        end else if (w17_vf > 32'(HUM_MAX)) begin
            n17_hum = HUM_W'(HUM_MAX >> 12);
        end else begin
            n17_hum = w17_vf[28:12];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r1_a0      <= n1_a0;
            r1_b0      <= n1_b0;
            r_pp_dl[1] <= 21'(PRESS_BASE) - {1'b0, i_sample.raw_press};
            r_rh_dl[1] <= i_sample.raw_hum;
            for (int k = 2; k <= 9; k++) r_pp_dl[k] <= r_pp_dl[k-1];
            for (int k = 2; k <= 5; k++) r_rh_dl[k] <= r_rh_dl[k-1];
            // stages 2 to 5
            r2_ma  <= w2_ma[31:0];
            r2_mb  <= w2_mb[31:0];
            r3_a   <= w3_a[20:0];
            r3_mbt <= w3_mbt[31:0];
            r4_tf  <= n4_tf;
            r5_v1  <= n5_v1;
            r5_hv  <= n5_hv;
            r_temp_dl[STG_TEMP] <= 24'(w5_t >>> 8);
            for (int k = STG_TEMP + 1; k <= STG_LAST; k++) r_temp_dl[k] <= r_temp_dl[k-1];
            // pressure stages 6 to 12
            r6_sq   <= n6_sq;
            r6_m5   <= n6_m5;
            r6_m2   <= n6_m2;
            r7_x6   <= n7_x6;
            r7_x3   <= n7_x3;
            r7_v2p  <= n7_v2p;
            r7_m2   <= r6_m2;
            r8_v2   <= n8_v2;
            r8_v1b  <= n8_v1b;
            r9_s    <= n9_s;
            r9_d    <= n9_d;
            r10_nlo <= r9_d[31:0] * 44'(PRESS_SCALE);
            r10_nhi <= r9_d[63:32] * 32'(PRESS_SCALE);
            r10_slo <= w10_s64[31:0] * 48'(p1);
            r10_shi <= w10_s64[63:32] * 32'(p1);
            r11_num <= n11_num;
            r11_den <= n11_den;
            r_dv_rem[0] <= '0;
            r_dv_dq[0]  <= r11_num[63] ? (64'd0 - r11_num) : r11_num;
            r_dv_md[0]  <= w12_inv ? 31'd1 :
                           (r11_den[30] ? (31'd0 - r11_den) : r11_den);
            r_dv_neg[0] <= r11_num[63] ^ r11_den[30];
            r_inv_dl[STG_DIV_IN] <= w12_inv;
            for (int k = STG_DIV_IN + 1; k <= STG_LAST; k++) r_inv_dl[k] <= r_inv_dl[k-1];
            // divider stages
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_dq[k]  <= {r_dv_dq[k-1][62:0], w_dv_ge[k]};
                r_dv_md[k]  <= r_dv_md[k-1];
                r_dv_neg[k] <= r_dv_neg[k-1];
            end
            // pressure stages 77 to 83
            r77_p     <= r_dv_neg[DIV_STEPS] ? (64'd0 - r_dv_dq[DIV_STEPS])
                                             : r_dv_dq[DIV_STEPS];
            r78_ll    <= w78_ps[31:0] * 64'(w78_ps[31:0]);
            r78_lh    <= w78_ps[31:0] * w78_ps[63:32];
            r78_w2lo  <= $signed({1'b0, r77_p[31:0]}) * p8;
            r78_w2hi  <= r77_p[63:32] * 32'(p8);
            r78_p     <= r77_p;
            r79_sq    <= r78_ll + {r78_lh[30:0], 33'b0};
            r79_w2raw <= 64'(r78_w2lo) + {r78_w2hi, 32'b0};
            r79_p     <= r78_p;
            r80_x9lo  <= $signed({1'b0, r79_sq[31:0]}) * p9;
            r80_x9hi  <= r79_sq[63:32] * 32'(p9);
            r80_w2    <= $signed(r79_w2raw) >>> 19;
            r80_p     <= r79_p;
            r81_w1    <= $signed(w81_x) >>> 25;
            r81_w2    <= r80_w2;
            r81_p     <= r80_p;
            r82_s     <= r81_p[39:0] + r81_w1[39:0] + r81_w2[39:0];
            r83_press <= r_inv_dl[STG_LAST-1] ? '0 : w83_res[31:8];
            // humidity stages 6 to 17
            r6_hm    <= w6_hm[31:0];
            r6_hbase <= n6_hbase;
            r7_v     <= 17'($signed(w7_hx) >>> 15);
            r8_ha0   <= r7_v * h6;
            r8_hb0   <= r7_v * $signed({1'b0, h3});
            r_hv_dl[8] <= r7_v;
            for (int k = 9; k <= 14; k++) r_hv_dl[k] <= r_hv_dl[k-1];
            r9_ha    <= 15'(r8_ha0 >>> 10);
            r9_hb    <= 17'(r8_hb0 >>> 11) + 17'(HUM_HB_OFS);
            r10_hc0  <= r9_ha * r9_hb;
            r11_hc   <= 32'(r10_hc0 >>> 10) + 32'(HUM_HC_OFS);
            r12_hd0  <= w12_hd[31:0];
            r13_hd   <= 18'($signed(r12_hd0 + 32'(HUM_HD_RND)) >>> 14);
            r14_vv   <= w14_vv[31:0];
            r15_sq   <= w15_sq[31:0];
            r15_vv   <= r14_vv;
            r16_t    <= w16_t[31:0];
            r16_vv   <= r15_vv;
            r_hum_dl[STG_HUM] <= n17_hum;
            for (int k = STG_HUM + 1; k <= STG_LAST; k++) r_hum_dl[k] <= r_hum_dl[k-1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STG_LAST-1:1], i_sample.valid};
        end
    end

    // two-entry output buffer
    assign w_res.temp_centi    = r_temp_dl[STG_LAST];
    assign w_res.press_pascal  = r83_press;
    assign w_res.hum_q10       = r_hum_dl[STG_LAST];
    assign w_res.press_invalid = r_inv_dl[STG_LAST];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ob[r_ob_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= '0;
        end else begin
            if (w_push) r_ob_wp <= ~r_ob_wp;
            if (w_pop)  r_ob_rp <= ~r_ob_rp;
            r_ob_cnt <= r_ob_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_result.valid         = (r_ob_cnt != 2'd0);
    assign o_result.temp_centi    = r_ob[r_ob_rp].temp_centi;
    assign o_result.press_pascal  = r_ob[r_ob_rp].press_pascal;
    assign o_result.hum_q10       = r_ob[r_ob_rp].hum_q10;
    assign o_result.press_invalid = r_ob[r_ob_rp].press_invalid;

endmodule
